// ----- design/orq_pkg.sv -----
// Package for the outstanding request table.
// Holds the opcode and status codes, the stored entry and result types and the sizes
// that do not vary. No dependencies.
package orq_pkg;

    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = 5;

    typedef enum logic [2:0] {
        OP_ADD        = 3'd0,
        OP_TAKE       = 3'd1,
        OP_LOOKUP     = 3'd2,
        OP_EXPIRE     = 3'd3,
        OP_DROP_EP    = 3'd4,
        OP_DROP_ATT   = 3'd5,
        OP_DROP_EPOCH = 3'd6,
        OP_ALLOC      = 3'd7
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EXISTS   = 3'd1,
        ST_STALE    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_NONE     = 3'd4,
        ST_FULL     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADDR,
        S_CHECK,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [3:0]  channel;
        logic [63:0] req_id;
        logic [31:0] attach_id;
        logic [7:0]  endpoint;
        logic [15:0] epoch;
        logic [31:0] deadline;
    } t_entry;

    typedef struct packed {
        t_status status;
        logic    last;
        t_entry  entry;
    } t_result;

endpackage

// ----- design/orq_if.sv -----
// Channel interfaces of the outstanding request table: request and response.
// Each carries valid, ready and the payload fields. No dependencies.
interface orq_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [3:0]  channel;
    logic [63:0] req_id;
    logic [31:0] attach_id;
    logic [7:0]  endpoint_address;
    logic [15:0] device_epoch;
    logic [31:0] deadline_tick;
    logic [31:0] now_tick;

    modport source(output valid, opcode, channel, req_id, attach_id, endpoint_address,
                   device_epoch, deadline_tick, now_tick, input ready);
    modport sink(input valid, opcode, channel, req_id, attach_id, endpoint_address,
                 device_epoch, deadline_tick, now_tick, output ready);
endinterface

interface orq_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        last;
    logic [3:0]  out_channel;
    logic [63:0] out_request_id;
    logic [31:0] out_attach_id;
    logic [7:0]  out_endpoint;
    logic [15:0] out_epoch;
    logic [31:0] out_deadline;

    modport source(output valid, status, last, out_channel, out_request_id, out_attach_id,
                   out_endpoint, out_epoch, out_deadline, input ready);
    modport sink(input valid, status, last, out_channel, out_request_id, out_attach_id,
                 out_endpoint, out_epoch, out_deadline, output ready);
endinterface

// ----- design/outstanding_request_table.sv -----
// Outstanding request table: one request transaction in, one or more response
// transactions out. Requests arrive on i_req and responses leave on o_rsp, both
// valid/ready channels; a transaction moves when valid and ready are high together.
// A single slot compare unit walks the table one slot at a time under a small
// sequencer. For each visited slot, S_ADDR reads the slot memory into a register
// and S_CHECK tests the registered entry. Add and the sweeps walk the whole table
// unless they stop early: add stops on a live key, and a sweep stops after its
// 16th removal. Take and lookup stop at the first hit. Allocate visits no slot:
// its sequencer goes from S_ADDR straight to S_FINISH. The next request can be
// accepted once the sequencer is back in S_IDLE. A sweep sends one response per
// removed entry, in slot order, at most 16 of them, or one ST_NONE if none
// matches. The last response of each request has last set.
// i_req.ready is high only while the sequencer is idle, so one request is in work
// at a time. The response register lets a new request start while a response waits.
// When o_rsp stalls, the sequencer holds at the next response it has to send.
// Synchronous reset empties the table, clears the per-channel history and the id
// counters, and drops any response not yet taken.
// Depends on orq_pkg and orq_if.
module outstanding_request_table #(
    parameter int ENTRIES  = 16,
    parameter int CHANNELS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    orq_req_if.sink   i_req,
    orq_rsp_if.source o_rsp
);
    import orq_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    t_state  r_state, n_state;
    t_opcode r_op;
    logic [3:0]  r_ch;
    logic [63:0] r_id;
    logic [31:0] r_att;
    logic [7:0]  r_ep;
    logic [15:0] r_epoch;
    logic [31:0] r_dl;
    logic [31:0] r_now;

    logic [ENTRIES-1:0] r_valid;
    t_entry r_slot_mem [ENTRIES];
    t_entry r_slot_rd;
    logic [IW-1:0] r_idx;

    logic [CHANNELS-1:0] r_seen;
    logic [CHANNELS-1:0] r_nid_ok;
    logic [63:0] r_last_mem [CHANNELS];
    logic [63:0] r_next_mem [CHANNELS];
    logic [63:0] r_last_rd;
    logic [63:0] r_next_rd;

    logic          r_found;
    logic          r_free_ok;
    logic [IW-1:0] r_free_idx;
    logic          r_have_pend;
    t_entry        r_pend;
    logic [CNT_W-1:0] r_cnt;

    logic    r_ovalid;
    t_result r_o;

    // Channel numbers fold onto the per-channel state; the fold is a constant table.
    logic [CW-1:0] w_ci_tab [16];
    logic [CW-1:0] w_ci;

    for (genvar g = 0; g < 16; g++) begin : g_fold
        localparam int FOLD = g % CHANNELS;
        assign w_ci_tab[g] = CW'(FOLD);
    end
    assign w_ci = w_ci_tab[r_ch];

    logic w_acc, w_can_push, w_is_sweep, w_slot_v, w_key, w_match, w_last_slot;
    logic w_push, w_clr, w_wr_slot, w_wr_chan, w_wr_next, w_load_pend, w_found_set;
    logic w_free_set;
    logic [63:0] w_alloc;
    t_result w_res;

    assign w_acc       = i_req.valid & i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_can_push  = !r_ovalid || o_rsp.ready;
    assign w_is_sweep  = (r_op == OP_EXPIRE) || (r_op == OP_DROP_EP) ||
                         (r_op == OP_DROP_ATT) || (r_op == OP_DROP_EPOCH);
    assign w_slot_v    = r_valid[r_idx];
    assign w_key       = w_slot_v && (r_slot_rd.channel == r_ch) &&
                         (r_slot_rd.req_id == r_id);
    assign w_last_slot = (r_idx == IW'(ENTRIES - 1));
    assign w_alloc     = (r_nid_ok[w_ci] && (r_next_rd != 64'd0)) ? r_next_rd : 64'd1;

    // The shared slot test of the sweeps.
    always_comb begin
        w_match = 1'b0;
        unique case (r_op)
            OP_EXPIRE:  w_match = (r_now >= r_slot_rd.deadline);
            OP_DROP_EP: w_match = (r_slot_rd.attach_id == r_att) &&
                                  (r_slot_rd.endpoint == r_ep);
            OP_DROP_ATT: w_match = (r_slot_rd.attach_id == r_att);
            OP_DROP_EPOCH: w_match = (r_slot_rd.attach_id == r_att) &&
                                     (r_slot_rd.epoch != r_epoch);
            default: w_match = 1'b0;
        endcase
        w_match = w_match && w_slot_v;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                n_state = (r_op == OP_ALLOC) ? S_FINISH : S_CHECK;
            end
            S_CHECK: begin
                priority if ((r_op == OP_ADD) && w_key) begin
                    n_state = S_FINISH;
                end else if (((r_op == OP_TAKE) || (r_op == OP_LOOKUP)) && w_key) begin
                    n_state = S_FINISH;
                end else if (w_is_sweep && w_match && r_have_pend && !w_can_push) begin
                    n_state = S_CHECK;
                end else if (w_is_sweep && w_match &&
                             (r_cnt == CNT_W'(MAX_RESULTS - 1))) begin
                    n_state = S_FINISH;
                end else if (w_last_slot) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_ADDR;
                end
            end
            S_FINISH: begin
                if (w_can_push) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control and result for the current state.
    always_comb begin
        w_push      = 1'b0;
        w_clr       = 1'b0;
        w_wr_slot   = 1'b0;
        w_wr_chan   = 1'b0;
        w_wr_next   = 1'b0;
        w_load_pend = 1'b0;
        w_found_set = 1'b0;
        w_free_set  = 1'b0;
        w_res       = '0;
        w_res.status = ST_OK;
        unique case (r_state)
            S_CHECK: begin
                if (r_op == OP_ADD) begin
                    w_found_set = w_key;
                    w_free_set  = !w_slot_v && !r_free_ok;
                end else if ((r_op == OP_TAKE) || (r_op == OP_LOOKUP)) begin
                    w_found_set = w_key;
                    w_load_pend = w_key;
                    w_clr       = w_key && (r_op == OP_TAKE);
                end else if (w_is_sweep && w_match && (!r_have_pend || w_can_push)) begin
                    // The previous hit goes out now that a later one is known.
                    w_push       = r_have_pend;
                    w_res.status = ST_OK;
                    w_res.last   = 1'b0;
                    w_res.entry  = r_pend;
                    w_load_pend  = 1'b1;
                    w_clr        = 1'b1;
                end
            end
            S_FINISH: begin
                if (w_can_push) begin
                    w_push     = 1'b1;
                    w_res.last = 1'b1;
                    if (r_op == OP_ADD) begin
                        priority if (r_found) begin
                            w_res.status = ST_EXISTS;
                        end else if (r_seen[w_ci] && (r_id <= r_last_rd)) begin
                            w_res.status = ST_STALE;
                        end else if (!r_free_ok) begin
                            w_res.status = ST_FULL;
                        end else begin
                            w_res.status = ST_OK;
                            w_wr_slot    = 1'b1;
                            w_wr_chan    = 1'b1;
                        end
                    end else if ((r_op == OP_TAKE) || (r_op == OP_LOOKUP)) begin
                        if (r_found) begin
                            w_res.entry = r_pend;
                        end else begin
                            w_res.status = ST_NOTFOUND;
                        end
                    end else if (r_op == OP_ALLOC) begin
                        w_res.entry.channel = r_ch;
                        w_res.entry.req_id  = w_alloc;
                        w_wr_next           = 1'b1;
                    end else begin
                        if (r_have_pend) begin
                            w_res.entry = r_pend;
                        end else begin
                            w_res.status = ST_NONE;
                        end
                    end
                end
            end
            default: begin
                w_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_seen      <= '0;
            r_nid_ok    <= '0;
            r_found     <= 1'b0;
            r_free_ok   <= 1'b0;
            r_have_pend <= 1'b0;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_acc) begin
                r_found     <= 1'b0;
                r_free_ok   <= 1'b0;
                r_have_pend <= 1'b0;
                r_cnt       <= '0;
                r_idx       <= '0;
            end
            if ((r_state == S_CHECK) && (n_state == S_ADDR)) begin
                r_idx <= IW'(r_idx + 1'b1);
            end
            if (w_found_set) begin
                r_found <= 1'b1;
            end
            if (w_free_set) begin
                r_free_ok <= 1'b1;
            end
            if (w_load_pend && w_is_sweep) begin
                r_have_pend <= 1'b1;
                r_cnt       <= CNT_W'(r_cnt + 1'b1);
            end
            if (w_clr) begin
                r_valid[r_idx] <= 1'b0;
            end
            if (w_wr_slot) begin
                r_valid[r_free_idx] <= 1'b1;
            end
            if (w_wr_chan) begin
                r_seen[w_ci] <= 1'b1;
            end
            if (w_wr_next) begin
                r_nid_ok[w_ci] <= 1'b1;
            end
            if (w_push) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers and memories.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_op    <= t_opcode'(i_req.opcode);
            r_ch    <= i_req.channel;
            r_id    <= i_req.req_id;
            r_att   <= i_req.attach_id;
            r_ep    <= i_req.endpoint_address;
            r_epoch <= i_req.device_epoch;
            r_dl    <= i_req.deadline_tick;
            r_now   <= i_req.now_tick;
        end
        if (w_free_set) begin
            r_free_idx <= r_idx;
        end
        if (w_load_pend) begin
            r_pend <= r_slot_rd;
        end
        if (w_push) begin
            r_o <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_slot) begin
            r_slot_mem[r_free_idx] <= '{channel: r_ch, req_id: r_id, attach_id: r_att,
                                        endpoint: r_ep, epoch: r_epoch, deadline: r_dl};
        end
        r_slot_rd <= r_slot_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_chan) begin
            r_last_mem[w_ci] <= r_id;
        end
        if (w_wr_next) begin
            r_next_mem[w_ci] <= w_alloc + 64'd1;
        end
        r_last_rd <= r_last_mem[w_ci];
        r_next_rd <= r_next_mem[w_ci];
    end

    assign o_rsp.valid          = r_ovalid;
    assign o_rsp.status         = r_o.status;
    assign o_rsp.last           = r_o.last;
    assign o_rsp.out_channel    = r_o.entry.channel;
    assign o_rsp.out_request_id = r_o.entry.req_id;
    assign o_rsp.out_attach_id  = r_o.entry.attach_id;
    assign o_rsp.out_endpoint   = r_o.entry.endpoint;
    assign o_rsp.out_epoch      = r_o.entry.epoch;
    assign o_rsp.out_deadline   = r_o.entry.deadline;

endmodule

// ----- design/orq_checker.sv -----
// Port checker for the outstanding request table, with the bind that attaches it.
// Depends on orq_pkg and on the ports of outstanding_request_table.
module orq_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_status,
    input logic       i_last
);
    import orq_pkg::*;

    // A response that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("response withdrawn while stalled");

    // A request transaction keeps the table busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted while a request is in work");

    // Only defined status codes leave the block.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status <= 3'(ST_FULL)))
        else $error("undefined status code");

    // Every failure or empty sweep closes its request.
    a_fail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != 3'(ST_OK)) |-> i_last)
        else $error("non-ok response without last");

endmodule

bind outstanding_request_table orq_checker u_orq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_last      (o_rsp.last)
);

// ----- bench/orq_checker.sv -----
`timescale 1ns / 100ps
// Response checker for the outstanding request table: predicts each response
// transaction from the accepted requests and compares field by field.
// Depends on orq_pkg and orq_if.
module orq_predictor (
    input  logic   i_clk,
    input  logic   i_rst_n,
    orq_req_if     req,
    orq_rsp_if     rsp,
    output int     o_errors,
    output int     o_pending,
    output int     o_results
);
    import orq_pkg::*;

    localparam int SLOTS = 16;

    logic        tbl_valid [SLOTS];
    t_entry      tbl_entry [SLOTS];
    logic        chan_seen [16];
    logic [63:0] chan_last [16];
    logic [63:0] chan_next [16];

    t_result     expected_rsp [$];

    function automatic void add_expected(t_result r);
        expected_rsp.insert(expected_rsp.size(), r);
    endfunction

    function automatic t_result status_only(t_status st);
        t_result r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic int find_slot(logic [3:0] ch, logic [63:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (tbl_valid[i] && tbl_entry[i].channel == ch && tbl_entry[i].req_id == id)
                return i;
        return -1;
    endfunction

    function automatic bit sweep_hit(int s, t_opcode op);
        case (op)
            OP_EXPIRE:  return req.now_tick >= tbl_entry[s].deadline;
            OP_DROP_EP: return tbl_entry[s].attach_id == req.attach_id &&
                               tbl_entry[s].endpoint == req.endpoint_address;
            OP_DROP_ATT: return tbl_entry[s].attach_id == req.attach_id;
            default:    return tbl_entry[s].attach_id == req.attach_id &&
                               tbl_entry[s].epoch != req.device_epoch;
        endcase
    endfunction

    task automatic predict_request();
        t_opcode op;
        int      s;
        int      n;
        t_result r;
        op = t_opcode'(req.opcode);
        case (op)
            OP_ADD: begin
                s = -1;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!tbl_valid[i]) s = i;
                if (find_slot(req.channel, req.req_id) >= 0)
                    add_expected(status_only(ST_EXISTS));
                else if (chan_seen[req.channel] && req.req_id <= chan_last[req.channel])
                    add_expected(status_only(ST_STALE));
                else if (s < 0)
                    add_expected(status_only(ST_FULL));
                else begin
                    chan_seen[req.channel] = 1'b1;
                    chan_last[req.channel] = req.req_id;
                    tbl_valid[s] = 1'b1;
                    tbl_entry[s] = '{req.channel, req.req_id, req.attach_id,
                                     req.endpoint_address, req.device_epoch,
                                     req.deadline_tick};
                    add_expected(status_only(ST_OK));
                end
            end
            OP_TAKE, OP_LOOKUP: begin
                s = find_slot(req.channel, req.req_id);
                if (s < 0) begin
                    add_expected(status_only(ST_NOTFOUND));
                end else begin
                    r = '0;
                    r.status = ST_OK;
                    r.last = 1'b1;
                    r.entry = tbl_entry[s];
                    add_expected(r);
                    if (op == OP_TAKE) tbl_valid[s] = 1'b0;
                end
            end
            OP_ALLOC: begin
                if (chan_next[req.channel] == 64'd0) chan_next[req.channel] = 64'd1;
                r = status_only(ST_OK);
                r.entry.channel = req.channel;
                r.entry.req_id = chan_next[req.channel];
                chan_next[req.channel] = chan_next[req.channel] + 64'd1;
                add_expected(r);
            end
            default: begin
                n = 0;
                for (int i = 0; i < SLOTS && n < MAX_RESULTS; i++) begin
                    if (tbl_valid[i] && sweep_hit(i, op)) begin
                        r = '0;
                        r.status = ST_OK;
                        r.entry = tbl_entry[i];
                        add_expected(r);
                        tbl_valid[i] = 1'b0;
                        n++;
                    end
                end
                if (n == 0) add_expected(status_only(ST_NONE));
                else expected_rsp[$].last = 1'b1;
            end
        endcase
    endtask

    task automatic compare_response();
        t_result want;
        t_result got;
        got.status = t_status'(rsp.status);
        got.last = rsp.last;
        got.entry = '{rsp.out_channel, rsp.out_request_id, rsp.out_attach_id,
                      rsp.out_endpoint, rsp.out_epoch, rsp.out_deadline};
        if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected response transaction %h", $time, got);
            o_errors++;
        end else begin
            want = expected_rsp.pop_front();
            if (got.status !== want.status || got.last !== want.last ||
                got.entry !== want.entry) begin
                $display("%0t: response mismatch: expected status %0d last %0b entry %h",
                         $time, want.status, want.last, want.entry);
                $display("%0t:                    actual   status %0d last %0b entry %h",
                         $time, got.status, got.last, got.entry);
                o_errors++;
            end
        end
        o_results++;
    endtask

    initial begin
        o_errors = 0;
        o_results = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
            for (int i = 0; i < 16; i++) begin
                chan_seen[i] = 1'b0;
                chan_next[i] = 64'd0;
            end
            expected_rsp.delete();
        end else begin
            // Responses are compared before the new request is predicted; the two
            // never belong to the same request since the block takes one at a time.
            if (rsp.valid && rsp.ready) compare_response();
            if (req.valid && req.ready) predict_request();
        end
        o_pending = expected_rsp.size();
    end
endmodule

// ----- bench/outstanding_request_table_test.sv -----
`timescale 1ns / 100ps
// Top of the outstanding request table testbench: clock, reset, request stimulus
// and response stalls. Depends on orq_pkg, orq_if, orq_checker and the block.
module outstanding_request_table_test;
    import orq_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors;
    int   pending;
    int   results;
    int   quiet_cycles = 0;
    int   sent = 0;
    bit   long_hold = 1'b0;

    orq_req_if req ();
    orq_rsp_if rsp ();

    outstanding_request_table dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req.sink),
        .o_rsp  (rsp.source)
    );

    orq_predictor checker_inst (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .req      (req),
        .rsp      (rsp),
        .o_errors (errors),
        .o_pending(pending),
        .o_results(results)
    );

    always #5 i_clk = ~i_clk;

    // Small pools of keys and attach values so sweeps and lookups actually hit.
    logic [31:0] attach_pool [4] = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'hA5A5_0001};
    logic [63:0] next_id [16];

    task automatic send_request(t_opcode op, logic [3:0] ch, logic [63:0] id,
                                logic [31:0] att, logic [7:0] ep, logic [15:0] epoch,
                                logic [31:0] dl, logic [31:0] now);
        req.valid <= 1'b1;
        req.opcode <= op;
        req.channel <= ch;
        req.req_id <= id;
        req.attach_id <= att;
        req.endpoint_address <= ep;
        req.device_epoch <= epoch;
        req.deadline_tick <= dl;
        req.now_tick <= now;
        do @(posedge i_clk); while (!req.ready);
        sent++;
    endtask

    task automatic gap();
        req.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    task automatic random_request();
        t_opcode     op;
        logic [3:0]  ch;
        logic [63:0] id;
        int          pick;
        ch = 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 35) op = OP_ADD;
        else if (pick < 50) op = OP_TAKE;
        else if (pick < 60) op = OP_LOOKUP;
        else if (pick < 92) op = t_opcode'($urandom_range(3, 6));
        else op = OP_ALLOC;
        if (op == OP_ADD && $urandom_range(0, 9) != 0) begin
            next_id[ch] = next_id[ch] + $urandom_range(1, 3);
            id = next_id[ch];
        end else if ($urandom_range(0, 3) != 0) begin
            id = next_id[ch] - $urandom_range(0, 2);
        end else begin
            id = {$urandom, $urandom};
        end
        send_request(op, ch, id,
                     ($urandom_range(0, 4) == 0) ? $urandom : attach_pool[$urandom_range(0, 3)],
                     $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 2)),
                     $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1)),
                     $urandom, $urandom);
    endtask

    initial begin
        req.valid = 1'b0;
        req.opcode = OP_ADD;
        req.channel = '0;
        req.req_id = '0;
        req.attach_id = '0;
        req.endpoint_address = '0;
        req.device_epoch = '0;
        req.deadline_tick = '0;
        req.now_tick = '0;
        for (int i = 0; i < 16; i++) next_id[i] = 64'd100;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every operation, full table, a sweep at the 16-result limit.
        send_request(OP_ALLOC, 4'd15, 0, 0, 0, 0, 0, 0);
        send_request(OP_ALLOC, 4'd15, 0, 0, 0, 0, 0, 0);
        send_request(OP_ADD, 4'd0, 64'd0, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
        send_request(OP_ADD, 4'd0, 64'd0, 0, 0, 0, 0, 0);
        send_request(OP_ADD, 4'd1, '1, 0, 0, 0, 0, 0);
        send_request(OP_ADD, 4'd1, 64'd5, 0, 0, 0, 0, 0);
        send_request(OP_LOOKUP, 4'd1, '1, 0, 0, 0, 0, 0);
        send_request(OP_TAKE, 4'd1, '1, 0, 0, 0, 0, 0);
        send_request(OP_TAKE, 4'd1, '1, 0, 0, 0, 0, 0);
        for (int i = 0; i < 17; i++)
            send_request(OP_ADD, 4'd15, 64'(i + 1), 32'h7, 8'(i % 2), 16'(i % 3),
                         32'(i), 0);
        send_request(OP_EXPIRE, 4'd0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_request(OP_EXPIRE, 4'd0, 0, 0, 0, 0, 0, 32'd0);
        send_request(OP_DROP_EP, 0, 0, 32'h7, 8'd0, 0, 0, 0);
        send_request(OP_DROP_EPOCH, 0, 0, 32'h7, 0, 16'd1, 0, 0);
        send_request(OP_DROP_ATT, 0, 0, 32'h7, 0, 0, 0, 0);

        while (sent < 450) begin
            repeat ($urandom_range(1, 12)) random_request();
            if ($urandom_range(0, 2) != 0) gap();
        end
        req.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("Sent %0d requests covering all eight operations; checked %0d responses.",
                 sent, results);
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    // Response stalls, with one long hold-off while requests keep coming.
    initial begin
        rsp.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (sent > 200 && !long_hold) begin
                long_hold = 1'b1;
                rsp.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            if (sent > 300 && sent < 360) rsp.ready <= 1'b1;
            else rsp.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles.", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end
endmodule
